@@ design/sort_then_snake_layout_macros.svh @@
// assertion macros for the sorted snake layout block
`ifndef SORT_THEN_SNAKE_LAYOUT_MACROS_SVH
`define SORT_THEN_SNAKE_LAYOUT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define STSL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("stsl assertion failed");

// implication whose consequent is checked in the next cycle
`define STSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stsl assertion failed");

`else

`define STSL_ASSERT(lbl, prop)
`define STSL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ design/stsl_pkg.sv @@
// shared types, constants and helpers of the sorted snake layout block
package stsl_pkg;

    localparam int MAX_ROWS   = 8;
    localparam int MAX_COLS   = 8;
    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 4;
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W     = 3;

    localparam logic [CFG_W-1:0] ROWS_LIMIT = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] COLS_LIMIT = CFG_W'(MAX_COLS);

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EVEN,
        ST_FILL,
        ST_EMIT
    } t_state;

    // what one cell hands to its neighbors
    typedef struct packed {
        logic  occ;
        logic  ins;
        t_data value;
    } t_cell_link;

    // broadcast control for the whole chain
    typedef struct packed {
        logic  clear;
        logic  insert;
        logic  shift;
        t_data value;
    } t_chain_ctrl;

    localparam t_cell_link LINK_NONE = '{occ: 1'b0, ins: 1'b0, value: '0};

    function automatic logic [CFG_W-1:0] f_clamp_size(input logic [CFG_W-1:0] v,
                                                      input logic [CFG_W-1:0] limit);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > limit) begin
            r = limit;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ design/stsl_cell.sv @@
// one sorting cell: holds one value, inserts from the broadcast or takes a neighbor's
module stsl_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stsl_pkg::t_chain_ctrl i_ctrl,
    input  stsl_pkg::t_cell_link  i_left,
    input  stsl_pkg::t_cell_link  i_right,
    output stsl_pkg::t_cell_link  o_link
);
    import stsl_pkg::*;

    logic  r_occ;
    logic  n_occ;
    t_data r_value;
    t_data n_value;
    logic  w_ins;

    // new value belongs here or further left
    assign w_ins = !r_occ || (r_value > i_ctrl.value);

    assign o_link.occ   = r_occ;
    assign o_link.ins   = w_ins;
    assign o_link.value = r_value;

    always_comb begin
        n_occ   = r_occ;
        n_value = r_value;
        if (i_ctrl.clear) begin
            n_occ = 1'b0;
        end else if (i_ctrl.insert) begin
            if (i_left.ins) begin
                n_occ   = i_left.occ;
                n_value = i_left.value;
            end else if (w_ins) begin
                n_occ   = 1'b1;
                n_value = i_ctrl.value;
            end
        end else if (i_ctrl.shift) begin
            n_occ   = i_right.occ;
            n_value = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ design/stsl_chain.sv @@
// row of sorting cells: sorted insert per cycle, pops the smallest value from the head
module stsl_chain (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  stsl_pkg::t_chain_ctrl               i_ctrl,
    output stsl_pkg::t_data                     o_head,
    output logic [stsl_pkg::CELL_COUNT-1:0]     o_occ
);
    import stsl_pkg::*;

    t_cell_link w_link [CELL_COUNT];

    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
        t_cell_link w_left;
        t_cell_link w_right;

        if (g == 0) begin : g_first
            assign w_left = LINK_NONE;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end

        if (g == CELL_COUNT - 1) begin : g_last
            assign w_right = LINK_NONE;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end

        stsl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (i_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );

        assign o_occ[g] = w_link[g].occ;
    end

    assign o_head = w_link[0].value;

endmodule

@@ design/sort_then_snake_layout.sv @@
// top level: config registers, sorting chain and snake-order readout
//
// channel   direction  handshake                       payload
// input     in         i_in_valid / o_in_stall         i_element_value
// output    out        o_out_valid / i_out_stall       o_out_value, o_row_end, o_matrix_end
// config    in         psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// loading takes one request per cycle; each value is inserted in sorted place
// along the cell chain in the cycle it arrives.
// after the last value the input stalls while the chain drains from its head:
// an even row is emitted straight from the head, an odd row is first parked in the row stack
// and then emitted reversed; the output side may stall the emission of either kind of row.
// reset is synchronous; cells come up empty and both size registers read 8.
// a size register write discards a partly loaded matrix.
`include "sort_then_snake_layout_macros.svh"

module sort_then_snake_layout (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  stsl_pkg::t_data                i_element_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output stsl_pkg::t_data                o_out_value,
    output logic                           o_row_end,
    output logic                           o_matrix_end,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [stsl_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import stsl_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CFG_W-1:0] r_row_count;
    logic [CFG_W-1:0] r_column_count;
    logic [CNT_W-1:0] r_loaded;
    logic [CNT_W-1:0] n_loaded;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic             r_out_valid;
    logic             n_out_valid;
    t_data            r_out_value;
    t_data            n_out_value;
    logic             r_row_end;
    logic             n_row_end;
    logic             r_matrix_end;
    logic             n_matrix_end;
    t_data            r_stack [MAX_COLS];

    logic             w_cfg_wr;
    logic             w_in_acc;
    logic             w_out_free;
    logic             w_stack_we;
    logic [CFG_W-1:0] w_rows;
    logic [CFG_W-1:0] w_cols;
    logic [ROW_W-1:0] w_rows_m1;
    logic [COL_W-1:0] w_cols_m1;
    logic [CNT_W-1:0] w_total;
    logic             w_last_row;
    t_chain_ctrl      w_ctrl;
    t_data            w_head;
    logic [CELL_COUNT-1:0] w_occ;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_COLUMN_COUNT) ? {28'd0, r_column_count}
                                                     : {28'd0, r_row_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= ROWS_LIMIT;
            r_column_count <= COLS_LIMIT;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_ROW_COUNT) begin
                r_row_count <= pwdata[CFG_W-1:0];
            end else begin
                r_column_count <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign w_rows     = f_clamp_size(r_row_count, ROWS_LIMIT);
    assign w_cols     = f_clamp_size(r_column_count, COLS_LIMIT);
    assign w_rows_m1  = ROW_W'(w_rows - CFG_W'(1));
    assign w_cols_m1  = COL_W'(w_cols - CFG_W'(1));
    assign w_total    = CNT_W'(w_rows) * CNT_W'(w_cols);
    assign w_last_row = (r_row == w_rows_m1);

    assign o_in_stall = (r_state != ST_LOAD);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    stsl_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_head  (w_head),
        .o_occ   (w_occ)
    );

    always_comb begin
        n_state      = r_state;
        n_loaded     = r_loaded;
        n_row        = r_row;
        n_col        = r_col;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_value  = r_out_value;
        n_row_end    = r_row_end;
        n_matrix_end = r_matrix_end;
        w_stack_we   = 1'b0;
        w_ctrl.clear  = w_cfg_wr;
        w_ctrl.insert = 1'b0;
        w_ctrl.shift  = 1'b0;
        w_ctrl.value  = i_element_value;

        unique case (r_state)
            ST_LOAD: begin
                if (w_cfg_wr) begin
                    n_loaded = '0;
                end else if (w_in_acc) begin
                    w_ctrl.insert = 1'b1;
                    if (r_loaded + CNT_W'(1) == w_total) begin
                        n_loaded = '0;
                        n_row    = '0;
                        n_col    = '0;
                        n_state  = ST_EVEN;
                    end else begin
                        n_loaded = r_loaded + CNT_W'(1);
                    end
                end
            end
            ST_EVEN: begin
                if (w_out_free) begin
                    w_ctrl.shift = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_value  = w_head;
                    n_row_end    = (r_col == w_cols_m1);
                    n_matrix_end = (r_col == w_cols_m1) && w_last_row;
                    if (r_col == w_cols_m1) begin
                        n_col = '0;
                        if (w_last_row) begin
                            n_state = ST_LOAD;
                        end else begin
                            n_row   = r_row + ROW_W'(1);
                            n_state = ST_FILL;
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            ST_FILL: begin
                // odd row: park it in the stack, read back reversed
                w_ctrl.shift = 1'b1;
                w_stack_we   = 1'b1;
                if (r_col == w_cols_m1) begin
                    n_state = ST_EMIT;
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_stack[r_col];
                    n_row_end    = (r_col == '0);
                    n_matrix_end = (r_col == '0) && w_last_row;
                    if (r_col == '0) begin
                        if (w_last_row) begin
                            n_state = ST_LOAD;
                        end else begin
                            n_row   = r_row + ROW_W'(1);
                            n_state = ST_EVEN;
                        end
                    end else begin
                        n_col = r_col - COL_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_loaded    <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_row_end    <= n_row_end;
        r_matrix_end <= n_matrix_end;
        if (w_stack_we) begin
            r_stack[r_col] <= w_head;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_row_end    = r_row_end;
    assign o_matrix_end = r_matrix_end;

    `STSL_ASSERT(a_mend_has_rend, (o_out_valid && o_matrix_end) |-> o_row_end)
    `STSL_ASSERT(a_drain_count_zero, (r_state != ST_LOAD) |-> (r_loaded == '0))
    `STSL_ASSERT(a_occ_matches_count, (r_state == ST_LOAD) |-> ($countones(w_occ) == r_loaded))
    `STSL_ASSERT_NEXT(a_fill_to_emit, (r_state == ST_FILL) && (r_col == w_cols_m1), r_state == ST_EMIT)

endmodule
